// ----- rtl/lens_flare_pixel_compositor_unit_assert.svh -----
// Assertion helpers, included by rtl/lfpc_fifo.sv.
`ifndef LENS_FLARE_PIXEL_COMPOSITOR_UNIT_ASSERT_SVH
`define LENS_FLARE_PIXEL_COMPOSITOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define LFPC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define LFPC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lfpc_pkg.sv -----
package lfpc_pkg;

  localparam int RING_COUNT = 4;
  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;
  localparam int FRAC_W     = 16;
  localparam int PCT_W      = 7;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int COORD_W    = 12;
  localparam int CHAN_W     = 8;
  localparam int Q16_W      = 17;
  localparam int CTR_W      = 21;
  localparam int POS_W      = 23;
  localparam int DIST_W     = 14;
  localparam int SQ_W       = 2 * DIST_W;
  localparam int SUM_W      = 27;
  localparam int NUM_W      = 27;

  localparam int SQRT_STEPS = DIST_W;
  localparam int DIV_STEPS  = 16;
  localparam int RING_LAT   = SQRT_STEPS + DIV_STEPS + 4;
  localparam int QUO_BITS   = 8;
  localparam int BLEND_LAT  = QUO_BITS + 4;
  localparam int BACK_LAT   = RING_LAT + BLEND_LAT;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [Q16_W-1:0] ONE_Q16         = 17'h10000;
  localparam logic [Q16_W-1:0] ALPHA_THRESHOLD = 17'd655;
  localparam logic [23:0]      BQ_RECIP        = 24'd10737419;
  localparam int               BQ_SHIFT        = 14;
  localparam logic [PCT_W-1:0] PCT_MAX         = 7'd100;

  localparam logic [DIM_W-1:0]  RST_WIDTH   = 13'd1024;
  localparam logic [DIM_W-1:0]  RST_HEIGHT  = 13'd1024;
  localparam logic [FRAC_W-1:0] RST_CENTER  = 16'd32768;
  localparam logic [PCT_W-1:0]  RST_BRIGHT  = 7'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_CENTER_X     = 3'd2,
    CFG_CENTER_Y     = 3'd3,
    CFG_BRIGHTNESS   = 3'd4
  } cfg_idx_t;

  localparam logic [FRAC_W-1:0] RING_OFF_MAG [RING_COUNT] = '{16'd0, 16'd13107, 16'd9830, 16'd19661};
  localparam logic [RING_COUNT-1:0] RING_OFF_NEG = 4'b0100;
  localparam logic [5:0] RING_RAD [RING_COUNT] = '{6'd30, 6'd20, 6'd40, 6'd15};
  localparam logic [Q16_W-1:0] RING_INT [RING_COUNT] = '{17'd65536, 17'd39322, 17'd26214,
                                                         17'd19661};
  localparam logic [CHAN_W-1:0] RING_COL [RING_COUNT][3] = '{
    '{8'd255, 8'd255, 8'd200},
    '{8'd200, 8'd220, 8'd255},
    '{8'd255, 8'd180, 8'd100},
    '{8'd180, 8'd255, 8'd180}
  };

  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [FRAC_W-1:0] center_x_frac;
    logic [FRAC_W-1:0] center_y_frac;
    logic [PCT_W-1:0]  brightness_pct;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pix_t;

  typedef struct packed {
    logic [RING_COUNT-1:0][DIST_W-1:0] ax;
    logic [RING_COUNT-1:0][DIST_W-1:0] ay;
    logic [RING_COUNT-1:0]             near;
    pix_t                              pix;
  } item_t;

  // Floor division by 255, one base-256 digit per step.
  function automatic logic [39:0] div255(input logic [39:0] x);
    logic [7:0]  r;
    logic [8:0]  s;
    logic [39:0] q;
    r = '0;
    q = '0;
    for (int b = 4; b >= 0; b--) begin
      s = 9'(r) + 9'(x[b*8 +: 8]);
      if (s >= 9'd255) begin
        q[b*8 +: 8] = r + 8'd1;
        r = 8'(s - 9'd255);
      end else begin
        q[b*8 +: 8] = r;
        r = s[7:0];
      end
    end
    return q;
  endfunction

endpackage

// ----- rtl/lfpc_fifo.sv -----
`include "lens_flare_pixel_compositor_unit_assert.svh"

module lfpc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lfpc_pkg::item_t din,
  input  logic            pop,
  output lfpc_pkg::item_t dout,
  output logic            full,
  output logic            empty
);

  lfpc_pkg::item_t mem [lfpc_pkg::FIFO_DEPTH];
  logic [lfpc_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [lfpc_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [lfpc_pkg::FIFO_CNT_W-1:0] count;

  assign full  = (count == lfpc_pkg::FIFO_CNT_W'(lfpc_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `LFPC_ASSERT_IMP(a_count_bound, 1'b1, count <= lfpc_pkg::FIFO_CNT_W'(lfpc_pkg::FIFO_DEPTH), "queue count beyond depth")
  `LFPC_ASSERT_IMP(a_push_full, push, !full, "push into a full queue")
  `LFPC_ASSERT_NXT(a_pop_drains, pop && !push && !empty, count == $past(count) - 1'b1, "pop did not drain")

endmodule

// ----- rtl/lfpc_front.sv -----
module lfpc_front (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  lfpc_pkg::cfg_t                                          cfg,
  input  logic                                                    in_valid,
  output logic                                                    in_ready,
  input  logic [lfpc_pkg::COORD_W-1:0]                            pos_x,
  input  logic [lfpc_pkg::COORD_W-1:0]                            pos_y,
  input  lfpc_pkg::pix_t                                          pix,
  input  logic                                                    full,
  output logic                                                    push,
  output lfpc_pkg::item_t                                         item,
  output logic [lfpc_pkg::Q16_W-1:0]                              bq,
  output logic [lfpc_pkg::RING_COUNT-1:0][lfpc_pkg::DIST_W-1:0]   rad
);

  localparam int RC = lfpc_pkg::RING_COUNT;
  localparam int PW = lfpc_pkg::POS_W;

  logic [lfpc_pkg::DIM_W-1:0] wc;
  logic [lfpc_pkg::DIM_W-1:0] hc;
  logic [lfpc_pkg::PCT_W-1:0] pctc;
  logic [28:0] cx_p;
  logic [28:0] cy_p;
  logic [RC-1:0][28:0] ox_p;
  logic [RC-1:0][28:0] oy_p;
  logic [30:0] bq_p;
  logic [RC-1:0][22:0] rad_p;

  logic [lfpc_pkg::CTR_W-1:0] cx;
  logic [lfpc_pkg::CTR_W-1:0] cy;
  logic [RC-1:0][lfpc_pkg::CTR_W-1:0] ox;
  logic [RC-1:0][lfpc_pkg::CTR_W-1:0] oy;

  logic fen;
  logic f1_v;
  logic [lfpc_pkg::COORD_W-1:0] f1_px;
  logic [lfpc_pkg::COORD_W-1:0] f1_py;
  lfpc_pkg::pix_t f1_pix;
  logic [RC-1:0][PW-1:0] rcx_c;
  logic [RC-1:0][PW-1:0] rcy_c;

  logic f2_v;
  logic [lfpc_pkg::COORD_W-1:0] f2_px;
  logic [lfpc_pkg::COORD_W-1:0] f2_py;
  logic [RC-1:0][PW-1:0] f2_rcx;
  logic [RC-1:0][PW-1:0] f2_rcy;
  lfpc_pkg::pix_t f2_pix;
  logic [PW-1:0] dx;
  logic [PW-1:0] dy;
  logic [PW-1:0] adx;
  logic [PW-1:0] ady;

  always_comb begin
    if (cfg.image_width == '0) begin
      wc = lfpc_pkg::DIM_W'(1);
    end else if (cfg.image_width > lfpc_pkg::DIM_W'(lfpc_pkg::MAX_DIM)) begin
      wc = lfpc_pkg::DIM_W'(lfpc_pkg::MAX_DIM);
    end else begin
      wc = cfg.image_width;
    end
    if (cfg.image_height == '0) begin
      hc = lfpc_pkg::DIM_W'(1);
    end else if (cfg.image_height > lfpc_pkg::DIM_W'(lfpc_pkg::MAX_DIM)) begin
      hc = lfpc_pkg::DIM_W'(lfpc_pkg::MAX_DIM);
    end else begin
      hc = cfg.image_height;
    end
    pctc = (cfg.brightness_pct > lfpc_pkg::PCT_MAX) ? lfpc_pkg::PCT_MAX : cfg.brightness_pct;
    cx_p = 29'(cfg.center_x_frac) * 29'(wc);
    cy_p = 29'(cfg.center_y_frac) * 29'(hc);
    for (int i = 0; i < RC; i++) begin
      ox_p[i]  = 29'(lfpc_pkg::RING_OFF_MAG[i]) * 29'(wc);
      oy_p[i]  = 29'(lfpc_pkg::RING_OFF_MAG[i]) * 29'(hc);
      rad_p[i] = 23'(lfpc_pkg::RING_RAD[i]) * 23'(bq);
    end
    bq_p = 31'(pctc) * 31'(lfpc_pkg::BQ_RECIP);
  end

  // Geometry derived from the configuration, refreshed every cycle.
  always_ff @(posedge clk) begin
    cx <= cx_p[28:8];
    cy <= cy_p[28:8];
    for (int i = 0; i < RC; i++) begin
      ox[i]  <= ox_p[i][28:8];
      oy[i]  <= oy_p[i][28:8];
      rad[i] <= rad_p[i][21:8];
    end
    bq <= bq_p[30:lfpc_pkg::BQ_SHIFT];
  end

  always_comb begin
    for (int i = 0; i < RC; i++) begin
      if (lfpc_pkg::RING_OFF_NEG[i]) begin
        rcx_c[i] = PW'(cx) - PW'(ox[i]);
        rcy_c[i] = PW'(cy) - PW'(oy[i]);
      end else begin
        rcx_c[i] = PW'(cx) + PW'(ox[i]);
        rcy_c[i] = PW'(cy) + PW'(oy[i]);
      end
    end
  end

  assign fen      = !f2_v || !full;
  assign in_ready = fen;
  assign push     = f2_v && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else if (fen) begin
      f1_v <= in_valid;
      f2_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      f1_px  <= pos_x;
      f1_py  <= pos_y;
      f1_pix <= pix;
      f2_px  <= f1_px;
      f2_py  <= f1_py;
      f2_pix <= f1_pix;
      f2_rcx <= rcx_c;
      f2_rcy <= rcy_c;
    end
  end

  always_comb begin
    item.pix = f2_pix;
    for (int i = 0; i < RC; i++) begin
      dx  = {3'b000, f2_px, 8'h00} - f2_rcx[i];
      dy  = {3'b000, f2_py, 8'h00} - f2_rcy[i];
      adx = dx[PW-1] ? -dx : dx;
      ady = dy[PW-1] ? -dy : dy;
      item.ax[i]   = adx[lfpc_pkg::DIST_W-1:0];
      item.ay[i]   = ady[lfpc_pkg::DIST_W-1:0];
      item.near[i] = (adx[PW-1:lfpc_pkg::DIST_W] == '0) && (ady[PW-1:lfpc_pkg::DIST_W] == '0);
    end
  end

endmodule

// ----- rtl/lfpc_ring.sv -----
module lfpc_ring (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [lfpc_pkg::DIST_W-1:0]   ax,
  input  logic [lfpc_pkg::DIST_W-1:0]   ay,
  input  logic                          near,
  input  logic [lfpc_pkg::DIST_W-1:0]   rad,
  input  logic [lfpc_pkg::Q16_W-1:0]    intensity,
  output logic [lfpc_pkg::Q16_W-1:0]    wt
);

  localparam int DW = lfpc_pkg::DIST_W;
  localparam int SW = lfpc_pkg::SQ_W;
  localparam int NS = lfpc_pkg::SQRT_STEPS;
  localparam int ND = lfpc_pkg::DIV_STEPS;

  logic [SW-1:0] xx;
  logic [SW-1:0] yy;
  logic          n1;
  logic [SW:0]   s_c;
  logic [SW-1:0] v0;
  logic          n2;

  logic [SW-1:0] sq_v [NS];
  logic [SW-1:0] sq_r [NS];
  logic          sq_n [NS];

  logic [DW-1:0] dv_r [ND];
  logic [ND-1:0] dv_q [ND];
  logic          dv_h [ND];

  logic [DW-1:0]  root;
  logic [16:0]    f_c;
  logic [33:0]    ff_c;
  logic [16:0]    f2;
  logic           h2;
  logic [33:0]    wp_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      xx <= SW'(ax) * SW'(ax);
      yy <= SW'(ay) * SW'(ay);
      n1 <= near;
    end
  end

  assign s_c = (SW + 1)'(xx) + (SW + 1)'(yy);

  always_ff @(posedge clk) begin
    if (adv) begin
      v0 <= s_c[SW-1:0];
      n2 <= n1 && !s_c[SW];
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    localparam logic [SW-1:0] BITV = SW'(1) << (SW - 2 - 2 * j);
    logic [SW-1:0] v_in;
    logic [SW-1:0] r_in;
    logic          n_in;
    logic [SW:0]   t;
    if (j == 0) begin : g_first
      assign v_in = v0;
      assign r_in = '0;
      assign n_in = n2;
    end else begin : g_next
      assign v_in = sq_v[j-1];
      assign r_in = sq_r[j-1];
      assign n_in = sq_n[j-1];
    end
    assign t = (SW + 1)'(r_in) + (SW + 1)'(BITV);
    always_ff @(posedge clk) begin
      if (adv) begin
        if ((SW + 1)'(v_in) >= t) begin
          sq_v[j] <= v_in - t[SW-1:0];
          sq_r[j] <= (r_in >> 1) + BITV;
        end else begin
          sq_v[j] <= v_in;
          sq_r[j] <= r_in >> 1;
        end
        sq_n[j] <= n_in;
      end
    end
  end

  assign root = sq_r[NS-1][DW-1:0];

  // Quotient of root / rad in Q0.16, one bit per stage.
  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [DW-1:0] r_in;
    logic [ND-1:0] q_in;
    logic          h_in;
    logic [DW:0]   r2;
    logic [DW:0]   diff;
    logic          ge;
    if (j == 0) begin : g_first
      assign r_in = root;
      assign q_in = '0;
      assign h_in = sq_n[NS-1] && (rad != '0) && (root < rad);
    end else begin : g_next
      assign r_in = dv_r[j-1];
      assign q_in = dv_q[j-1];
      assign h_in = dv_h[j-1];
    end
    assign r2   = {r_in, 1'b0};
    assign ge   = r2 >= (DW + 1)'(rad);
    assign diff = r2 - (DW + 1)'(rad);
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j] <= ge ? diff[DW-1:0] : r2[DW-1:0];
        dv_q[j] <= {q_in[ND-2:0], ge};
        dv_h[j] <= h_in;
      end
    end
  end

  assign f_c  = lfpc_pkg::ONE_Q16 - 17'(dv_q[ND-1]);
  assign ff_c = 34'(f_c) * 34'(f_c);
  assign wp_c = 34'(f2) * 34'(intensity);

  always_ff @(posedge clk) begin
    if (adv) begin
      f2 <= ff_c[32:16];
      h2 <= dv_h[ND-1];
      wt <= h2 ? wp_c[32:16] : '0;
    end
  end

endmodule

// ----- rtl/lfpc_blend.sv -----
module lfpc_blend (
  input  logic                                                  clk,
  input  logic                                                  adv,
  input  logic [lfpc_pkg::RING_COUNT-1:0][lfpc_pkg::Q16_W-1:0]  wt,
  input  lfpc_pkg::pix_t                                        pix_in,
  input  logic [lfpc_pkg::Q16_W-1:0]                            bq,
  output lfpc_pkg::pix_t                                        pix_out
);

  localparam int RC = lfpc_pkg::RING_COUNT;
  localparam int NW = lfpc_pkg::NUM_W;
  localparam int QB = lfpc_pkg::QUO_BITS;
  localparam int QW = lfpc_pkg::Q16_W;

  logic [lfpc_pkg::SUM_W-1:0] sum_c [3];
  logic [QW-1:0]              amax_c;

  logic [lfpc_pkg::SUM_W-1:0] b1_sum [3];
  logic [QW-1:0]              b1_amax;
  lfpc_pkg::pix_t             b1_pix;

  logic [43:0]   sb_c [3];
  logic [QW-1:0] inv_c;
  logic [NW-1:0] b2_sb [3];
  logic [15:0]   b2_t [3];
  logic [24:0]   b2_y;
  logic [QW-1:0] b2_a;
  logic [QW-1:0] b2_inv;
  logic          b2_thr;
  lfpc_pkg::pix_t b2_pix;

  logic [39:0]   y_c;
  logic [32:0]   b3_x [3];
  logic [NW-1:0] b3_sb [3];
  logic [QW-1:0] b3_outa;
  logic          b3_thr;
  lfpc_pkg::pix_t b3_pix;

  logic [39:0]   x_c [3];
  logic [24:0]   oa_c;
  logic [NW-1:0] b4_num [3];
  logic [QW-1:0] b4_outa;
  logic [7:0]    b4_oa;
  logic          b4_thr;
  lfpc_pkg::pix_t b4_pix;

  logic [NW-1:0]  dq_r   [QB][3];
  logic [QB-1:0]  dq_q   [QB][3];
  logic           dq_sat [QB][3];
  logic [QW-1:0]  dq_outa [QB];
  logic [7:0]     dq_oa  [QB];
  logic           dq_thr [QB];
  lfpc_pkg::pix_t dq_pix [QB];

  logic [7:0] res [3];

  always_comb begin
    amax_c = '0;
    for (int k = 0; k < 3; k++) begin
      sum_c[k] = '0;
      for (int i = 0; i < RC; i++) begin
        sum_c[k] = sum_c[k] + lfpc_pkg::SUM_W'(25'(lfpc_pkg::RING_COL[i][k]) * 25'(wt[i]));
      end
    end
    for (int i = 0; i < RC; i++) begin
      if (wt[i] > amax_c) begin
        amax_c = wt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_sum  <= sum_c;
      b1_amax <= amax_c;
      b1_pix  <= pix_in;
    end
  end

  always_comb begin
    inv_c = lfpc_pkg::ONE_Q16 - b1_amax;
    for (int k = 0; k < 3; k++) begin
      sb_c[k] = 44'(b1_sum[k]) * 44'(bq);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        b2_sb[k] <= sb_c[k][42:16];
      end
      b2_t[0] <= 16'(b1_pix.red) * 16'(b1_pix.alpha);
      b2_t[1] <= 16'(b1_pix.green) * 16'(b1_pix.alpha);
      b2_t[2] <= 16'(b1_pix.blue) * 16'(b1_pix.alpha);
      b2_y    <= 25'(b1_pix.alpha) * 25'(inv_c);
      b2_a    <= b1_amax;
      b2_inv  <= inv_c;
      b2_thr  <= b1_amax > lfpc_pkg::ALPHA_THRESHOLD;
      b2_pix  <= b1_pix;
    end
  end

  assign y_c = lfpc_pkg::div255(40'(b2_y));

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        b3_x[k]  <= 33'(b2_t[k]) * 33'(b2_inv);
        b3_sb[k] <= b2_sb[k];
      end
      b3_outa <= b2_a + y_c[QW-1:0];
      b3_thr  <= b2_thr;
      b3_pix  <= b2_pix;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      x_c[k] = lfpc_pkg::div255(40'(b3_x[k]));
    end
    oa_c = 25'(b3_outa) * 25'(255);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        b4_num[k] <= b3_sb[k] + x_c[k][NW-1:0];
      end
      b4_outa <= b3_outa;
      b4_oa   <= oa_c[23:16];
      b4_thr  <= b3_thr;
      b4_pix  <= b3_pix;
    end
  end

  // Channel quotient num / outa, one bit per stage, saturating at 255.
  for (genvar j = 0; j < QB; j++) begin : g_quo
    logic [NW-1:0]  r_in [3];
    logic [QB-1:0]  q_in [3];
    logic           s_in [3];
    logic [QW-1:0]  outa_in;
    logic [7:0]     oa_in;
    logic           thr_in;
    lfpc_pkg::pix_t pix_c;
    logic [NW-1:0]  d;
    if (j == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          r_in[k] = b4_num[k];
          q_in[k] = '0;
          s_in[k] = b4_num[k] >= (NW'(b4_outa) << QB);
        end
      end
      assign outa_in = b4_outa;
      assign oa_in   = b4_oa;
      assign thr_in  = b4_thr;
      assign pix_c   = b4_pix;
    end else begin : g_next
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          r_in[k] = dq_r[j-1][k];
          q_in[k] = dq_q[j-1][k];
          s_in[k] = dq_sat[j-1][k];
        end
      end
      assign outa_in = dq_outa[j-1];
      assign oa_in   = dq_oa[j-1];
      assign thr_in  = dq_thr[j-1];
      assign pix_c   = dq_pix[j-1];
    end
    assign d = NW'(outa_in) << (QB - 1 - j);
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < 3; k++) begin
          if (r_in[k] >= d) begin
            dq_r[j][k] <= r_in[k] - d;
            dq_q[j][k] <= {q_in[k][QB-2:0], 1'b1};
          end else begin
            dq_r[j][k] <= r_in[k];
            dq_q[j][k] <= {q_in[k][QB-2:0], 1'b0};
          end
          dq_sat[j][k] <= s_in[k];
        end
        dq_outa[j] <= outa_in;
        dq_oa[j]   <= oa_in;
        dq_thr[j]  <= thr_in;
        dq_pix[j]  <= pix_c;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res[k] = dq_sat[QB-1][k] ? 8'hFF : dq_q[QB-1][k];
    end
    if (dq_thr[QB-1]) begin
      pix_out.red   = res[0];
      pix_out.green = res[1];
      pix_out.blue  = res[2];
      pix_out.alpha = dq_oa[QB-1];
    end else begin
      pix_out = dq_pix[QB-1];
    end
  end

endmodule

// ----- rtl/lens_flare_pixel_compositor_unit.sv -----
// Lens flare compositor: one RGBA pixel with its coordinates in, one pixel out.
// Requests arrive on in_valid/in_ready with pos_x, pos_y and the four input
// channels; results leave on out_valid/out_ready in the same order.
// Configuration is written through cfg_write, cfg_index and cfg_data; the user
// must write only while the block is idle, which the block itself does not
// enforce. Each write takes effect at once and has no read-back. Throughput is
// one pixel per cycle while out_ready stays high. Accepted pixels pass two front
// stages, the queue, 34 stages of ring evaluation (a 14-step square root and a
// 16-step division) and 12 stages of compositing (an 8-step channel division).
// When out_valid is high and out_ready is low the whole back pipeline holds;
// the four-entry queue and the front keep taking requests until the queue
// fills, then in_ready drops. Synchronous reset empties the pipeline and queue
// and loads the register defaults: 1024 by 1024 image, centered flare, brightness 50.
module lens_flare_pixel_compositor_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lfpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfpc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lfpc_pkg::COORD_W-1:0]      pos_x,
  input  logic [lfpc_pkg::COORD_W-1:0]      pos_y,
  input  logic [lfpc_pkg::CHAN_W-1:0]       in_red,
  input  logic [lfpc_pkg::CHAN_W-1:0]       in_green,
  input  logic [lfpc_pkg::CHAN_W-1:0]       in_blue,
  input  logic [lfpc_pkg::CHAN_W-1:0]       in_alpha,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lfpc_pkg::CHAN_W-1:0]       out_red,
  output logic [lfpc_pkg::CHAN_W-1:0]       out_green,
  output logic [lfpc_pkg::CHAN_W-1:0]       out_blue,
  output logic [lfpc_pkg::CHAN_W-1:0]       out_alpha
);

  localparam int RC = lfpc_pkg::RING_COUNT;
  localparam int BL = lfpc_pkg::BACK_LAT;
  localparam int RL = lfpc_pkg::RING_LAT;

  lfpc_pkg::cfg_t  cfg;
  lfpc_pkg::pix_t  in_pix;
  lfpc_pkg::pix_t  out_pix;
  lfpc_pkg::item_t push_item;
  lfpc_pkg::item_t pop_item;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  logic            adv;
  logic [lfpc_pkg::Q16_W-1:0] bq;
  logic [RC-1:0][lfpc_pkg::DIST_W-1:0] rad;
  logic [RC-1:0][lfpc_pkg::Q16_W-1:0]  wt;
  logic [BL-1:0]   vld;
  lfpc_pkg::pix_t  ch_pipe [RL];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width    <= lfpc_pkg::RST_WIDTH;
      cfg.image_height   <= lfpc_pkg::RST_HEIGHT;
      cfg.center_x_frac  <= lfpc_pkg::RST_CENTER;
      cfg.center_y_frac  <= lfpc_pkg::RST_CENTER;
      cfg.brightness_pct <= lfpc_pkg::RST_BRIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        lfpc_pkg::CFG_IMAGE_WIDTH: begin
          cfg.image_width <= cfg_data[lfpc_pkg::DIM_W-1:0];
        end
        lfpc_pkg::CFG_IMAGE_HEIGHT: begin
          cfg.image_height <= cfg_data[lfpc_pkg::DIM_W-1:0];
        end
        lfpc_pkg::CFG_CENTER_X: begin
          cfg.center_x_frac <= cfg_data;
        end
        lfpc_pkg::CFG_CENTER_Y: begin
          cfg.center_y_frac <= cfg_data;
        end
        lfpc_pkg::CFG_BRIGHTNESS: begin
          cfg.brightness_pct <= cfg_data[lfpc_pkg::PCT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_pix.red   = in_red;
  assign in_pix.green = in_green;
  assign in_pix.blue  = in_blue;
  assign in_pix.alpha = in_alpha;

  lfpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pix      (in_pix),
    .full     (full),
    .push     (push),
    .item     (push_item),
    .bq       (bq),
    .rad      (rad)
  );

  lfpc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_item),
    .pop   (pop),
    .dout  (pop_item),
    .full  (full),
    .empty (empty)
  );

  assign adv = !vld[BL-1] || out_ready;
  assign pop = adv && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[BL-2:0], !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch_pipe[0] <= pop_item.pix;
      for (int s = 1; s < RL; s++) begin
        ch_pipe[s] <= ch_pipe[s-1];
      end
    end
  end

  for (genvar i = 0; i < RC; i++) begin : g_ring
    lfpc_ring u_ring (
      .clk       (clk),
      .adv       (adv),
      .ax        (pop_item.ax[i]),
      .ay        (pop_item.ay[i]),
      .near      (pop_item.near[i]),
      .rad       (rad[i]),
      .intensity (lfpc_pkg::RING_INT[i]),
      .wt        (wt[i])
    );
  end

  lfpc_blend u_blend (
    .clk     (clk),
    .adv     (adv),
    .wt      (wt),
    .pix_in  (ch_pipe[RL-1]),
    .bq      (bq),
    .pix_out (out_pix)
  );

  assign out_valid = vld[BL-1];
  assign out_red   = out_pix.red;
  assign out_green = out_pix.green;
  assign out_blue  = out_pix.blue;
  assign out_alpha = out_pix.alpha;

endmodule

// ----- test/tb_lens_flare_pixel_compositor_unit.sv -----
`timescale 1ns / 1ps

module tb_lens_flare_pixel_compositor_unit;

  localparam logic [lfpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [lfpc_pkg::COORD_W-1:0] x;
    logic [lfpc_pkg::COORD_W-1:0] y;
    lfpc_pkg::pix_t pix;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [lfpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lfpc_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [lfpc_pkg::COORD_W-1:0] pos_x = '0;
  logic [lfpc_pkg::COORD_W-1:0] pos_y = '0;
  logic [lfpc_pkg::CHAN_W-1:0] in_red = '0;
  logic [lfpc_pkg::CHAN_W-1:0] in_green = '0;
  logic [lfpc_pkg::CHAN_W-1:0] in_blue = '0;
  logic [lfpc_pkg::CHAN_W-1:0] in_alpha = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [lfpc_pkg::CHAN_W-1:0] out_red;
  logic [lfpc_pkg::CHAN_W-1:0] out_green;
  logic [lfpc_pkg::CHAN_W-1:0] out_blue;
  logic [lfpc_pkg::CHAN_W-1:0] out_alpha;

  lens_flare_pixel_compositor_unit DUT (.*);

  // Shadow copy of the configuration registers.
  lfpc_pkg::cfg_t shadow_cfg;

  request_t pixel_backlog[$];
  lfpc_pkg::pix_t composited_pixels[$];
  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_pct = 100;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned clamp_dim(longint unsigned d);
    if (d < 1) return 1;
    if (d > lfpc_pkg::MAX_DIM) return lfpc_pkg::MAX_DIM;
    return d;
  endfunction

  // Ring center along one axis, Q.8 pixels.
  function automatic longint ring_center(int i, longint unsigned dim, longint unsigned frac);
    longint c;
    longint o;
    c = longint'((frac * dim) >> 8);
    o = longint'((longint'(lfpc_pkg::RING_OFF_MAG[i]) * dim) >> 8);
    return lfpc_pkg::RING_OFF_NEG[i] ? c - o : c + o;
  endfunction

  function automatic lfpc_pkg::pix_t composite_flare(request_t r);
    longint unsigned w, h, pct, bq, amax, a, inv, outa, num, v, root, rad, f, wt;
    longint unsigned adx, ady;
    longint unsigned sum[3];
    longint unsigned chn[4];
    longint dx, dy;
    lfpc_pkg::pix_t res;
    w = clamp_dim(shadow_cfg.image_width);
    h = clamp_dim(shadow_cfg.image_height);
    pct = shadow_cfg.brightness_pct > lfpc_pkg::PCT_MAX ? 100 : shadow_cfg.brightness_pct;
    bq = pct * 65536 / 100;
    chn[0] = r.pix.red;
    chn[1] = r.pix.green;
    chn[2] = r.pix.blue;
    chn[3] = r.pix.alpha;
    sum = '{0, 0, 0};
    amax = 0;
    for (int i = 0; i < lfpc_pkg::RING_COUNT; i++) begin
      dx = longint'(r.x) * 256 - ring_center(i, w, shadow_cfg.center_x_frac);
      dy = longint'(r.y) * 256 - ring_center(i, h, shadow_cfg.center_y_frac);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      root = int_sqrt(adx * adx + ady * ady);
      rad = (longint'(lfpc_pkg::RING_RAD[i]) * bq) >> 8;
      if (rad == 0 || root >= rad) continue;
      f = 65536 - (root * 65536) / rad;
      f = (f * f) >> 16;
      wt = (f * lfpc_pkg::RING_INT[i]) >> 16;
      for (int k = 0; k < 3; k++) sum[k] += longint'(lfpc_pkg::RING_COL[i][k]) * wt;
      if (wt > amax) amax = wt;
    end
    if (amax > lfpc_pkg::ALPHA_THRESHOLD) begin
      a = amax > 65536 ? 65536 : amax;
      inv = 65536 - a;
      outa = a + (chn[3] * inv) / 255;
      for (int k = 0; k < 3; k++) begin
        num = ((sum[k] * bq) >> 16) + (chn[k] * chn[3] * inv) / 255;
        v = num / outa;
        chn[k] = v > 255 ? 255 : v;
      end
      chn[3] = ((outa * 255) >> 16) & 8'hFF;
    end
    res.red = chn[0];
    res.green = chn[1];
    res.blue = chn[2];
    res.alpha = chn[3];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    errors++;
  endtask

  // Driver: bursts of requests separated by random gaps.
  always @(posedge clk) begin
    request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        composited_pixels.push_back(composite_flare(
            '{pos_x, pos_y, '{in_red, in_green, in_blue, in_alpha}}));
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pixel_backlog.size() > 0) begin
        nxt = pixel_backlog.pop_front();
        pos_x <= nxt.x;
        pos_y <= nxt.y;
        in_red <= nxt.pix.red;
        in_green <= nxt.pix.green;
        in_blue <= nxt.pix.blue;
        in_alpha <= nxt.pix.alpha;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor with its own stall pattern.
  always @(posedge clk) begin
    lfpc_pkg::pix_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count % 250 == 0) ready_pct <= (cycle_count % 1000 == 0) ? 100 :
                                             $urandom_range(20, 90);
    out_ready <= !rst && ($urandom_range(0, 99) < ready_pct);
    if (!rst && out_valid && out_ready) begin
      if (composited_pixels.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = composited_pixels.pop_front();
        if (out_red !== want.red) report_mismatch("out_red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("out_green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("out_blue", out_blue, want.blue);
        if (out_alpha !== want.alpha) report_mismatch("out_alpha", out_alpha, want.alpha);
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("tb_lens_flare_pixel_compositor_unit NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [lfpc_pkg::CFG_IDX_W-1:0] idx,
                           logic [lfpc_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      lfpc_pkg::CFG_IMAGE_WIDTH: shadow_cfg.image_width = data[lfpc_pkg::DIM_W-1:0];
      lfpc_pkg::CFG_IMAGE_HEIGHT: shadow_cfg.image_height = data[lfpc_pkg::DIM_W-1:0];
      lfpc_pkg::CFG_CENTER_X: shadow_cfg.center_x_frac = data;
      lfpc_pkg::CFG_CENTER_Y: shadow_cfg.center_y_frac = data;
      lfpc_pkg::CFG_BRIGHTNESS: shadow_cfg.brightness_pct = data[lfpc_pkg::PCT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_setting(int w, int h, int cxf, int cyf, int pct);
    write_reg(lfpc_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(lfpc_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(lfpc_pkg::CFG_CENTER_X, cxf);
    write_reg(lfpc_pkg::CFG_CENTER_Y, cyf);
    write_reg(lfpc_pkg::CFG_BRIGHTNESS, pct);
    write_reg(CFG_SPARE_INDEX, $urandom);
  endtask

  task automatic wait_idle();
    wait (pixel_backlog.size() == 0 && !in_valid && composited_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int near_coord(int ring, bit is_y);
    longint c;
    if (is_y) c = ring_center(ring, clamp_dim(shadow_cfg.image_height),
                              shadow_cfg.center_y_frac);
    else c = ring_center(ring, clamp_dim(shadow_cfg.image_width),
                         shadow_cfg.center_x_frac);
    c = (c >>> 8) + $urandom_range(0, 90) - 45;
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return c;
  endfunction

  task automatic queue_pixel(int x, int y, int r, int g, int b, int a);
    request_t req;
    req.x = x;
    req.y = y;
    req.pix = '{r, g, b, a};
    pixel_backlog.push_back(req);
  endtask

  task automatic queue_random(int count);
    int ring;
    for (int n = 0; n < count; n++) begin
      ring = $urandom_range(0, lfpc_pkg::RING_COUNT - 1);
      if ($urandom_range(0, 9) < 7)
        queue_pixel(near_coord(ring, 0), near_coord(ring, 1), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      else
        queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  initial begin
    shadow_cfg = '{lfpc_pkg::RST_WIDTH, lfpc_pkg::RST_HEIGHT, lfpc_pkg::RST_CENTER,
                   lfpc_pkg::RST_CENTER, lfpc_pkg::RST_BRIGHT};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Defaults: coordinate extremes, ring centers, points near and far from the flare, random requests.
    queue_pixel(0, 0, 0, 0, 0, 0);
    queue_pixel(4095, 4095, 255, 255, 255, 255);
    queue_pixel(4095, 0, 255, 0, 255, 0);
    for (int i = 0; i < lfpc_pkg::RING_COUNT; i++) begin
      queue_pixel(ring_center(i, 1024, lfpc_pkg::RST_CENTER) >>> 8,
                  ring_center(i, 1024, lfpc_pkg::RST_CENTER) >>> 8, 0, 0, 0, 0);
      queue_pixel(ring_center(i, 1024, lfpc_pkg::RST_CENTER) >>> 8,
                  ring_center(i, 1024, lfpc_pkg::RST_CENTER) >>> 8, 255, 255, 255, 255);
      queue_pixel((ring_center(i, 1024, lfpc_pkg::RST_CENTER) >>> 8) + 10,
                  ring_center(i, 1024, lfpc_pkg::RST_CENTER) >>> 8, 17, 200, 90, 128);
    end
    queue_pixel(519, 512, 10, 20, 30, 255);
    queue_pixel(100, 900, 12, 34, 56, 78);
    queue_random(150);
    wait_idle();

    apply_setting(64, 48, 32768, 32768, 100);
    queue_random(150);
    wait_idle();
    apply_setting(0, 0, 0, 0, 0);
    queue_random(100);
    wait_idle();
    apply_setting(8191, 8191, 65535, 65535, 127);
    queue_random(150);
    wait_idle();
    apply_setting(4096, 4096, 16384, 49152, 100);
    queue_random(150);
    wait_idle();
    apply_setting(200, 100, 60000, 5000, 1);
    queue_random(100);
    wait_idle();
    for (int p = 0; p < 4; p++) begin
      apply_setting($urandom_range(1, 600), $urandom_range(1, 600), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 127));
      queue_random(130);
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb_lens_flare_pixel_compositor_unit OK");
    end else begin
      $display("tb_lens_flare_pixel_compositor_unit NOT OK");
    end
    $finish;
  end

endmodule
